/* sv/int_list_store_with_search_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the list store
// Implication checks sampled on the rising clock, off while in reset.
// ----------------------------------------------------------------------------
`ifndef INT_LIST_STORE_WITH_SEARCH_MACROS_SVH
`define INT_LIST_STORE_WITH_SEARCH_MACROS_SVH

// same-cycle implication
`define ILSS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// next-cycle implication
`define ILSS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

/* sv/ilss_pkg.sv */
// ----------------------------------------------------------------------------
// ilss_pkg
// Sizes, operation codes and status codes of the list store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ilss_pkg;

  localparam int CAPACITY = 256;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    MODE_APPEND  = 2'd0,
    MODE_PREPEND = 2'd1,
    MODE_READ    = 2'd2,
    MODE_SEARCH  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

endpackage

`default_nettype wire

/* sv/int_list_store_with_search.sv */
// ----------------------------------------------------------------------------
// int_list_store_with_search
// Bounded deque of signed 32-bit values held in a ring RAM, with append,
// prepend, read by position and first-match search.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// while the request runs and every request gives one result, shown for one
// cycle with out_valid. The receiver cannot stall: sample the result in the
// cycle out_valid is high. Append and prepend, a read past the end of the list
// and a search of an empty list finish in the execute state; any other read
// waits for the registered RAM read, and any other search runs until the
// first match or the last entry, walking the list one entry per cycle through
// the single RAM read port. A new request may start in the cycle its
// predecessor's result is shown. No clearing pass follows reset; the first
// request can start right after reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module int_list_store_with_search (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_mode,
  input  wire logic signed [31:0]              in_item_value,
  input  wire logic [7:0]                      in_position_in,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic signed [31:0]                   out_read_value,
  output logic [7:0]                           out_match_position,
  output logic [8:0]                           out_length
);
  import ilss_pkg::*;

  `include "int_list_store_with_search_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SRCH
  } state_t;

  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    front_r, front_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [PTR_W-1:0]    idx_r, idx_nxt;

  logic [1:0]          mode_r;
  logic [DATA_W-1:0]   value_r;
  logic [7:0]          pos_r;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_read_value_r, out_read_value_nxt;
  logic [7:0]          out_match_position_r, out_match_position_nxt;
  logic [8:0]          out_length_r, out_length_nxt;

  logic                accept;
  logic                full;
  logic [PTR_W-1:0]    front_dec;
  logic [PTR_W-1:0]    sel_pos;
  logic [PTR_W-1:0]    slot;
  logic                ram_we;
  logic [PTR_W-1:0]    ram_waddr;
  logic [DATA_W-1:0]   ram_rdata;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));

  assign front_dec = (front_r == '0) ? PTR_W'(CAPACITY - 1) : front_r - PTR_W'(1);

  always_comb begin
    if (state_r == S_EXEC) begin
      case (mode_r)
        MODE_APPEND: sel_pos = PTR_W'(count_r);
        MODE_READ:   sel_pos = PTR_W'(pos_r);
        default:     sel_pos = '0;
      endcase
    end else begin
      sel_pos = idx_r + PTR_W'(1);
    end
  end

  ilss_slot u_slot (
    .front (front_r),
    .pos   (sel_pos),
    .slot  (slot)
  );

  assign ram_waddr = (mode_r == MODE_PREPEND) ? front_dec : slot;

  ilss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value_r),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt              = state_r;
    front_nxt              = front_r;
    count_nxt              = count_r;
    idx_nxt                = idx_r;
    ram_we                 = 1'b0;
    out_valid_nxt          = 1'b0;
    out_status_nxt         = STAT_OK;
    out_read_value_nxt     = '0;
    out_match_position_nxt = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (mode_r)
          MODE_APPEND, MODE_PREPEND: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (full) begin
              out_status_nxt = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              if (mode_r == MODE_PREPEND) begin
                front_nxt = front_dec;
              end
            end
          end
          MODE_READ: begin
            if (32'(pos_r) < 32'(count_r)) begin
              state_nxt = S_RDWAIT;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_NOT_FOUND;
              state_nxt      = S_IDLE;
            end
          end
          default: begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_NOT_FOUND;
              state_nxt      = S_IDLE;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_SRCH;
            end
          end
        endcase
      end
      S_RDWAIT: begin
        out_valid_nxt      = 1'b1;
        out_read_value_nxt = ram_rdata;
        state_nxt          = S_IDLE;
      end
      S_SRCH: begin
        if (ram_rdata == value_r) begin
          out_valid_nxt          = 1'b1;
          out_read_value_nxt     = value_r;
          out_match_position_nxt = 8'(idx_r);
          state_nxt              = S_IDLE;
        end else if (CNT_W'(idx_r) + CNT_W'(1) == count_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NOT_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt = idx_r + PTR_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_length_nxt = 9'(count_nxt);
  end

  // hold the request while it runs
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      value_r <= in_item_value;
      pos_r   <= in_position_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= S_IDLE;
      front_r              <= '0;
      count_r              <= '0;
      idx_r                <= '0;
      out_valid_r          <= 1'b0;
      out_status_r         <= STAT_OK;
      out_read_value_r     <= '0;
      out_match_position_r <= '0;
      out_length_r         <= '0;
    end else begin
      state_r              <= state_nxt;
      front_r              <= front_nxt;
      count_r              <= count_nxt;
      idx_r                <= idx_nxt;
      out_valid_r          <= out_valid_nxt;
      out_status_r         <= out_status_nxt;
      out_read_value_r     <= out_read_value_nxt;
      out_match_position_r <= out_match_position_nxt;
      out_length_r         <= out_length_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_value     = out_read_value_r;
  assign out_match_position = out_match_position_r;
  assign out_length         = out_length_r;

  `ILSS_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `ILSS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  `ILSS_ASSERT_IMPLY(a_result_idle, clk, rst_n, out_valid_r, !busy)
  `ILSS_ASSERT_IMPLY(a_full_len, clk, rst_n, out_valid_r && out_status_r == STAT_FULL,
    out_length_r == 9'(CAPACITY))
  `ILSS_ASSERT_IMPLY(a_srch_nonempty, clk, rst_n, state_r == S_SRCH,
    CNT_W'(idx_r) < count_r)

endmodule

`default_nettype wire

/* sv/ilss_ram.sv */
// ----------------------------------------------------------------------------
// ilss_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/ilss_slot.sv */
// ----------------------------------------------------------------------------
// ilss_slot
// Ring address: front pointer plus list position, wrapped at capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilss_slot (
  input  wire logic [ilss_pkg::PTR_W-1:0] front,
  input  wire logic [ilss_pkg::PTR_W-1:0] pos,
  output logic      [ilss_pkg::PTR_W-1:0] slot
);
  import ilss_pkg::*;

  logic [PTR_W:0] sum;
  logic [PTR_W:0] wrapped;

  always_comb begin
    sum     = {1'b0, front} + {1'b0, pos};
    wrapped = sum - (PTR_W+1)'(CAPACITY);
    if (sum >= (PTR_W+1)'(CAPACITY)) begin
      slot = wrapped[PTR_W-1:0];
    end else begin
      slot = sum[PTR_W-1:0];
    end
  end

endmodule

`default_nettype wire
